### rtl/ndef_pkg.sv
// shared constants for the neighbor difference edge filter
// register indexes, field widths and reset values; no dependencies
package ndef_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W       = 24;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

endpackage

### rtl/ndef_cfg_regs.sv
// configuration registers for image width and height, with clamped values
// depends on ndef_pkg
module ndef_cfg_regs import ndef_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [((($clog2(MAX_WIDTH+1)) > WIDTH_REG_W) ?
                 $clog2(MAX_WIDTH+1) : WIDTH_REG_W)-1:0] width_eff,
  output logic [HEIGHT_W-1:0]   height_eff
);

  localparam int CW = (($clog2(MAX_WIDTH+1)) > WIDTH_REG_W) ?
                      $clog2(MAX_WIDTH+1) : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0] width_r;
  logic [HEIGHT_W-1:0]    height_r;
  logic [CW-1:0]          width_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // width is held to 2..MAX_WIDTH, a zero height acts as one row
  always_comb begin
    width_ext = CW'(width_r);
    if (width_ext < CW'(2)) begin
      width_eff = CW'(2);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    height_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

endmodule

### rtl/ndef_line_store.sv
// previous-row line store: one write port, one registered read port
// depends on ndef_pkg
module ndef_line_store import ndef_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]             wr_data,
  input  logic                         re,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [PIX_W-1:0]             rd_data
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ndef_pos_track.sv
// column and row counters of the raster, border flag and line store addresses
// depends on ndef_pkg
module ndef_pos_track import ndef_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [((($clog2(MAX_WIDTH+1)) > WIDTH_REG_W) ?
                 $clog2(MAX_WIDTH+1) : WIDTH_REG_W)-1:0] width_eff,
  input  logic [HEIGHT_W-1:0]          height_eff,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         interior
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (($clog2(MAX_WIDTH+1)) > WIDTH_REG_W) ?
                      $clog2(MAX_WIDTH+1) : WIDTH_REG_W;

  logic [AW-1:0]       col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [CW-1:0]       col_p1;
  logic [HEIGHT_W:0]   row_p1;
  logic                row_end;

  always_comb begin
    col_p1   = CW'(col_r) + CW'(1);
    row_p1   = {1'b0, row_r} + (HEIGHT_W+1)'(1);
    // a count at or past the last column ends the row
    row_end  = (col_p1 >= width_eff);
    interior = (col_r != '0) && !row_end && (row_r != '0);
    wr_addr  = col_r;
    // upper-right neighbor; past the store it is never used
    rd_addr  = (col_p1 < CW'(MAX_WIDTH)) ? col_p1[AW-1:0] : '0;

    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= {1'b0, height_eff}) ? '0 : row_p1[HEIGHT_W-1:0];
      end else begin
        col_nxt = col_p1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/neighbor_difference_edge_filter.sv
// top level of the neighbor difference edge filter
// depends on ndef_pkg, ndef_cfg_regs, ndef_line_store, ndef_pos_track
//
// usage:
//   pixels enter on in_pixel in raster order; a request is taken when
//   in_valid is high and in_stall is low. each pixel gives one result on
//   out_edge_value: the largest absolute difference to its left, upper and
//   upper-right neighbors, zero on the first row, first and last column.
//   image_width (index 0) and image_height (index 1) are written through
//   cfg_valid/cfg_index/cfg_data; cfg_ready is always high. write them
//   only while no pixel is in flight.
// timing:
//   a pixel passes the middle stage (s1), then the output register, where
//   out_valid rises with its result. one pixel per clock is sustained
//   while out_stall is low: the line store is read once per pixel at the
//   upper-right column, and the upper value is that read kept from the
//   pixel before. when out_stall holds the output register, a pixel is
//   still taken into an empty middle stage, then in_stall rises.
// reset:
//   rst_n (synchronous) empties the pipeline, clears the column and row
//   counts and sets width 640, height 480. the line store is not cleared;
//   the first row does not use what it reads.
module neighbor_difference_edge_filter import ndef_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_edge_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (($clog2(MAX_WIDTH+1)) > WIDTH_REG_W) ?
                      $clog2(MAX_WIDTH+1) : WIDTH_REG_W;

  logic [CW-1:0]       width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                interior;
  logic [PIX_W-1:0]    upr_data;

  logic                accept, adv_out;
  logic                s1_valid_r, s1_inside_r;
  logic [PIX_W-1:0]    s1_pix_r, s1_left_r, s1_up_r;
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_edge_r, edge_nxt;
  logic [PIX_W-1:0]    d_left, d_up, d_upr, d_max;

  ndef_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  ndef_pos_track #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .interior   (interior)
  );

  ndef_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk     (clk),
    .we      (accept),
    .wr_addr (wr_addr),
    .wr_data (in_pixel),
    .re      (accept),
    .rd_addr (rd_addr),
    .rd_data (upr_data)
  );

  assign cfg_ready = 1'b1;
  assign adv_out   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv_out;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    d_left = (s1_pix_r >= s1_left_r) ? s1_pix_r - s1_left_r : s1_left_r - s1_pix_r;
    d_up   = (s1_pix_r >= s1_up_r)   ? s1_pix_r - s1_up_r   : s1_up_r - s1_pix_r;
    d_upr  = (s1_pix_r >= upr_data)  ? s1_pix_r - upr_data  : upr_data - s1_pix_r;
    d_max  = d_left;
    if (d_up > d_max) begin
      d_max = d_up;
    end
    if (d_upr > d_max) begin
      d_max = d_upr;
    end
    edge_nxt = s1_inside_r ? d_max : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // the previous pixel and its upper-right read become left and upper here
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left_r   <= s1_pix_r;
      s1_up_r     <= upr_data;
      s1_pix_r    <= in_pixel;
      s1_inside_r <= interior;
    end
    if (adv_out && s1_valid_r) begin
      out_edge_r <= edge_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_r;

endmodule
